// File: rtl/aip_pkg.sv
package aip_pkg;

  // Offset counter width; end_position is this count cut or padded to 16 bits
  localparam int unsigned PosWidth = 16;
  localparam int unsigned EndPosWidth = 16;
  localparam int unsigned AccWidth = 32;

  // Character codes
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharLowA  = 8'h61;  // 'a'
  localparam logic [7:0] CharLowF  = 8'h66;  // 'f'
  localparam logic [7:0] CharMinus = 8'h2d;  // '-'

  typedef enum logic {
    RadixDec = 1'b0,
    RadixHex = 1'b1
  } radix_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic signed [AccWidth-1:0]    value;
    logic                          found;
    logic        [EndPosWidth-1:0] end_position;
  } out_word_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  // Classify one byte as a digit of the selected radix
  function automatic digit_t decode_digit(logic [7:0] c, radix_e radix);
    digit_t     d;
    logic [7:0] diff;
    begin
      d = '0;
      diff = '0;
      if (c >= CharZero && c <= CharNine) begin
        diff = c - CharZero;
        d.valid = 1'b1;
        d.value = diff[3:0];
      end else if (radix == RadixHex && c >= CharLowA && c <= CharLowF) begin
        diff = c - CharLowA + 8'd10;
        d.valid = 1'b1;
        d.value = diff[3:0];
      end
      return d;
    end
  endfunction

endpackage

// File: rtl/ascii_integer_parser.sv
// Channel  Direction  Word type             Handshake
// in       input      aip_pkg::in_word_t    in_valid_i / in_ready_o
// out      output     aip_pkg::out_word_t   out_valid_o / out_ready_i
// cfg      input      radix_mode (1 bit)    cfg_valid_i / cfg_ready_o
//
// One byte is taken per cycle; the result for a segment appears in the
// output register the cycle after its stopping or last byte is taken.
// The per-byte path is one constant shift-and-add into the accumulator
// followed by the optional two's complement negate of the result.
// Reset clears the parse state and the radix; nothing needs a warm-up.
// Input stalls only while a result sits unread in the output register.
module ascii_integer_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  aip_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output aip_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_radix_mode_i
);

  aip_pkg::radix_e                       radix_q, radix_d;
  logic [aip_pkg::AccWidth-1:0]          acc_q, acc_d;
  logic                                  neg_q, neg_d;
  logic                                  seen_q, seen_d;
  logic                                  fin_q, fin_d;
  logic [aip_pkg::PosWidth-1:0]          pos_q, pos_d;
  logic                                  out_valid_q, out_valid_d;
  aip_pkg::out_word_t                    out_word_q, out_word_d;

  logic                                  in_accept;
  aip_pkg::digit_t                       dig;
  logic [aip_pkg::AccWidth-1:0]          acc_upd;
  logic                                  neg_upd;
  logic                                  seen_upd;
  logic                                  fin_upd;
  logic                                  emit;
  logic [aip_pkg::PosWidth-1:0]          emit_pos;
  logic [aip_pkg::PosWidth-1:0]          pos_inc;
  logic [aip_pkg::AccWidth-1:0]          acc_next;

  // Output register frees up when taken; input flows whenever it is free
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign dig     = aip_pkg::decode_digit(in_word_i.char_code, radix_q);
  assign pos_inc = pos_q + 1'b1;

  // Accumulate: x10 as (x<<3)+(x<<1), x16 as a shift
  always_comb begin
    unique case (radix_q)
      aip_pkg::RadixHex: acc_next = {acc_q[aip_pkg::AccWidth-5:0], dig.value};
      default: acc_next = (acc_q << 3) + (acc_q << 1)
                          + {{(aip_pkg::AccWidth-4){1'b0}}, dig.value};
    endcase
  end

  // Per-byte parse step
  always_comb begin
    acc_upd  = acc_q;
    neg_upd  = neg_q;
    seen_upd = seen_q;
    fin_upd  = fin_q;
    emit     = 1'b0;
    emit_pos = pos_q;
    if (in_accept && !fin_q) begin
      if (dig.valid) begin
        acc_upd  = acc_next;
        seen_upd = 1'b1;
      end else if (seen_q) begin
        emit    = 1'b1;
        fin_upd = 1'b1;
      end else if (in_word_i.char_code == aip_pkg::CharMinus) begin
        neg_upd = 1'b1;
      end
      // segment ran out before a stop
      if (!fin_upd && in_word_i.last_char) begin
        emit     = 1'b1;
        emit_pos = pos_inc;
      end
    end
  end

  // Segment state; the last byte clears everything for the next segment
  always_comb begin
    acc_d  = acc_q;
    neg_d  = neg_q;
    seen_d = seen_q;
    fin_d  = fin_q;
    pos_d  = pos_q;
    if (in_accept) begin
      if (in_word_i.last_char) begin
        acc_d  = '0;
        neg_d  = 1'b0;
        seen_d = 1'b0;
        fin_d  = 1'b0;
        pos_d  = '0;
      end else begin
        acc_d  = acc_upd;
        neg_d  = neg_upd;
        seen_d = seen_upd;
        fin_d  = fin_upd;
        pos_d  = pos_inc;
      end
    end
  end

  // Result word and output valid
  always_comb begin
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_valid_d             = 1'b1;
      out_word_d.found        = seen_upd;
      out_word_d.end_position = aip_pkg::EndPosWidth'(emit_pos);
      if (!seen_upd) begin
        out_word_d.value = '0;
      end else if (neg_upd) begin
        out_word_d.value = $signed(-acc_upd);
      end else begin
        out_word_d.value = $signed(acc_upd);
      end
    end
  end

  // Radix register
  always_comb begin
    radix_d = radix_q;
    if (cfg_valid_i && cfg_ready_o) begin
      radix_d = aip_pkg::radix_e'(cfg_radix_mode_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= aip_pkg::RadixDec;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      fin_q       <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      radix_q     <= radix_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      seen_q      <= seen_d;
      fin_q       <= fin_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

endmodule

// File: bench/ascii_integer_parser_test.sv
module ascii_integer_parser_test;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomWords   = 1350;
  localparam int unsigned PhaseWords    = 225;

  // Tracks the parse of each segment and holds the results still to come
  class int_parse_scoreboard;
    aip_pkg::radix_e              radix;
    logic [aip_pkg::AccWidth-1:0] acc;
    logic                         neg;
    logic                         seen;
    logic                         done;
    logic [aip_pkg::PosWidth-1:0] pos;
    aip_pkg::out_word_t           pending_q[$];
    int unsigned                  mismatches;
    int unsigned                  words;
    int unsigned                  segments;
    int unsigned                  results;

    function new();
      radix      = aip_pkg::RadixDec;
      mismatches = 0;
      words      = 0;
      segments   = 0;
      results    = 0;
      clear_segment();
    endfunction

    function void clear_segment();
      acc  = '0;
      neg  = 1'b0;
      seen = 1'b0;
      done = 1'b0;
      pos  = '0;
    endfunction

    // Digit weight in the given radix, -1 for anything else
    static function int digit_of(logic [7:0] c, aip_pkg::radix_e r);
      if (c >= aip_pkg::CharZero && c <= aip_pkg::CharNine) begin
        return int'(c - aip_pkg::CharZero);
      end
      if (r == aip_pkg::RadixHex && c >= aip_pkg::CharLowA && c <= aip_pkg::CharLowF) begin
        return int'(c - aip_pkg::CharLowA) + 10;
      end
      return -1;
    endfunction

    function void push_result(logic [aip_pkg::PosWidth-1:0] stop_pos);
      aip_pkg::out_word_t w;
      w.value        = seen ? (neg ? -acc : acc) : '0;
      w.found        = seen;
      w.end_position = aip_pkg::EndPosWidth'(stop_pos);
      pending_q.push_back(w);
    endfunction

    // Called for every input word the block accepts
    function void note_input(aip_pkg::in_word_t w);
      int                           d;
      logic [aip_pkg::PosWidth-1:0] next_pos;
      logic [aip_pkg::AccWidth-1:0] mult;
      words++;
      next_pos = pos + 1'b1;
      mult = (radix == aip_pkg::RadixHex) ? 32'd16 : 32'd10;
      if (!done) begin
        d = digit_of(w.char_code, radix);
        if (d >= 0) begin
          acc  = acc * mult + d;
          seen = 1'b1;
        end else if (seen) begin
          // first non-digit after the number stops the parse
          push_result(pos);
          done = 1'b1;
        end else if (w.char_code == aip_pkg::CharMinus) begin
          neg = 1'b1;
        end
        if (!done && w.last_char) begin
          push_result(next_pos);
        end
      end
      if (w.last_char) begin
        clear_segment();
        segments++;
      end else begin
        pos = next_pos;
      end
    endfunction

    // Called for every output word the block hands over
    function void check_result(aip_pkg::out_word_t got);
      aip_pkg::out_word_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual value %0d found %0b end %0d",
                 $time, got.value, got.found, got.end_position);
        return;
      end
      want = pending_q.pop_front();
      results++;
      if (got.value !== want.value) begin
        mismatches++;
        $display("%0t: value mismatch: expected %0d, actual %0d",
                 $time, want.value, got.value);
      end
      if (got.found !== want.found) begin
        mismatches++;
        $display("%0t: found mismatch: expected %0b, actual %0b",
                 $time, want.found, got.found);
      end
      if (got.end_position !== want.end_position) begin
        mismatches++;
        $display("%0t: end_position mismatch: expected %0d, actual %0d",
                 $time, want.end_position, got.end_position);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  aip_pkg::in_word_t  in_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  aip_pkg::out_word_t out_word_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_radix_mode_i;

  int_parse_scoreboard sb;
  int unsigned         burst_left = 0;
  int unsigned         rx_cycle = 0;
  int unsigned         stall_left = 0;
  int unsigned         idle_cycles = 0;

  ascii_integer_parser u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_word_i        (in_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_word_o       (out_word_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_radix_mode_i (cfg_radix_mode_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Byte generators for the current radix
  function automatic logic [7:0] rand_digit();
    int unsigned v;
    v = (sb.radix == aip_pkg::RadixHex) ? $urandom_range(0, 15) : $urandom_range(0, 9);
    return (v < 10) ? aip_pkg::CharZero + 8'(v) : aip_pkg::CharLowA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] rand_non_digit();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (int_parse_scoreboard::digit_of(c, sb.radix) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] rand_noise();
    case ($urandom_range(0, 3))
      0: return rand_digit();
      1: return aip_pkg::CharMinus;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one word; the sender runs in bursts with random idle gaps, sometimes none, between them
  task automatic send_byte(input logic [7:0] c, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_word_i  <= '{char_code: c, last_char: last};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(in_word_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Mostly well-formed numbers with random framing, the rest pure noise
  task automatic send_random_segment(output int unsigned n);
    logic [7:0]  seg[$];
    int unsigned count;
    if ($urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(0, 3)) seg.push_back(rand_non_digit());
      if ($urandom_range(0, 1) == 1) begin
        seg.push_back(aip_pkg::CharMinus);
      end
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      repeat (count) seg.push_back(rand_digit());
      if ($urandom_range(0, 4) >= 2) begin
        seg.push_back(rand_non_digit());
        repeat ($urandom_range(0, 3)) seg.push_back(rand_noise());
      end
    end else begin
      repeat ($urandom_range(1, 8)) seg.push_back(rand_noise());
    end
    foreach (seg[k]) begin
      send_byte(seg[k], k == seg.size() - 1);
    end
    n = seg.size();
  endtask

  // Radix change only once the block has drained
  task automatic write_radix(input aip_pkg::radix_e r);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_radix_mode_i <= r;
    cfg_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.radix = r;
  endtask

  // Main stimulus
  initial begin
    int unsigned random_words;
    int unsigned phase_words;
    int unsigned n;
    int unsigned phase;
    sb               = new();
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_word_i        = '0;
    out_ready_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_radix_mode_i = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // decimal after reset: single digit, no digit, early stop, high bytes, stop on last
    send_text("9");
    send_byte(8'h00, 1'b0);
    send_byte("a", 1'b1);
    send_text("-42xz");
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("0");
    send_text("7-");
    // hex: wraps to the most negative value, upper-case letter stops
    write_radix(aip_pkg::RadixHex);
    send_text("-180000000");
    send_text("fA");
    send_text("12,x");

    random_words = 0;
    phase = 0;
    while (random_words < RandomWords) begin
      write_radix(phase % 2 == 1 ? aip_pkg::RadixHex : aip_pkg::RadixDec);
      phase_words = 0;
      while (phase_words < PhaseWords) begin
        send_random_segment(n);
        phase_words += n;
      end
      random_words += phase_words;
      phase++;
    end

    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d words in %0d segments over %0d radix phases, directed cases included",
             sb.words, sb.segments, phase + 2);
    $display("Checked %0d results", sb.results);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: check each word, stall on a pattern that shifts over time
  always @(posedge clk_i) begin
    logic ready_next;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_word_o);
      end
      rx_cycle++;
      ready_next = 1'b1;
      if (stall_left != 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        case ((rx_cycle / 128) % 4)
          0: ready_next = 1'b1;
          1: ready_next = 1'($urandom_range(0, 1));
          2: begin
            if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(1, 16);
              ready_next = 1'b0;
            end
          end
          default: ready_next = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_ready_i <= ready_next;
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

endmodule
